### hw/rtl/activation_function_unit_assert.svh
// Assertion helpers for the activation function unit.
// They expect clk and arst_n to be visible where they are used.
`ifndef ACTIVATION_FUNCTION_UNIT_ASSERT_SVH
`define ACTIVATION_FUNCTION_UNIT_ASSERT_SVH

// Plain property, checked at every edge outside reset
`define AFU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition in this cycle implies a consequence in the next one
`define AFU_ASSERT_NEXT(lbl, cond, nxt, msg) \
	`AFU_ASSERT(lbl, (cond) |=> (nxt), msg)

`endif

### hw/rtl/afu_pkg.sv
`default_nettype none

package afu_pkg;

	// Element width (signed fixed point)
	localparam int XW = 16;

	// Activation mode register codes
	typedef enum logic [2:0] {
		MODE_SIG      = 3'd0,
		MODE_SIG_DER  = 3'd1,
		MODE_TANH     = 3'd2,
		MODE_TANH_DER = 3'd3,
		MODE_IDENT    = 3'd4,
		MODE_ONE      = 3'd5
	} afu_mode_t;

	// Q32 constants for building the tables
	localparam longint unsigned Q32_ONE  = 64'h0000_0001_0000_0000;
	localparam longint unsigned Q32_EINV = 64'd1580030169;
	localparam int EXP_TERMS   = 20;
	localparam int EXP_MAX_INT = 16;

	// Unsigned quotient by restoring long division. Evaluated at elaboration only.
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-a in Q32 for a >= 0: Taylor series on the fraction, then e^-1 per integer step.
	// Evaluated at elaboration only.
	function automatic longint unsigned exp_neg_q32(input longint unsigned a);
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint unsigned v;
		longint sum;
		n = a >> 32;
		f = a & 64'h0000_0000_FFFF_FFFF;
		term = Q32_ONE;
		sum = longint'(Q32_ONE);
		for (int k = 1; k <= EXP_TERMS; k++) begin
			term = udiv64((term * f) >> 32, 64'(k));
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = unsigned'(sum);
		for (int k = 0; k < EXP_MAX_INT; k++) begin
			if (64'(k) < n && v != 0)
				v = (v * Q32_EINV) >> 32;
		end
		return v;
	endfunction

	// One table entry: f(a) with a = (j-half)*span/half, rounded half away from zero
	function automatic logic [XW-1:0] rom_entry(input bit is_tanh, input int j,
			input int half, input int span, input int frac);
		longint d;
		longint unsigned ad;
		longint unsigned a;
		longint unsigned e;
		longint unsigned den;
		longint unsigned r;
		d = longint'(j) - longint'(half);
		ad = unsigned'((d < 0) ? -d : d);
		a = udiv64(ad * 64'(span) * Q32_ONE, 64'(half));
		if (is_tanh) begin
			e = exp_neg_q32(2 * a);
			den = Q32_ONE + e;
			r = udiv64(((Q32_ONE - e) << frac) + (den >> 1), den);
			if (d < 0)
				r = -r;
		end else begin
			e = exp_neg_q32(a);
			den = Q32_ONE + e;
			if (d >= 0)
				r = udiv64((Q32_ONE << frac) + (den >> 1), den);
			else
				r = udiv64((e << frac) + (den >> 1), den);
		end
		return r[XW-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/afu_index.sv
`default_nettype none

// Table index: floor(x*HALF/(RANGE<<FRAC_BITS)) + HALF over three stages.
// The offset form n = (x + D)*HALF keeps the dividend nonnegative, and the
// quotient by the constant D comes from a reciprocal multiply plus one correction.
module afu_index import afu_pkg::*; #(
	parameter int SIG_HALF   = 256,
	parameter int SIG_RANGE  = 8,
	parameter int TANH_HALF  = 256,
	parameter int TANH_LIMIT = 4,
	parameter int FRAC_BITS  = 12,
	parameter int IDX_W      = 10
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic                  use_tanh,
	input  wire logic signed [XW-1:0]  x,
	output logic         [IDX_W-1:0]   idx_s3
);

	localparam int NW = 31;                   // offset dividend width
	localparam int RS = 31;                   // reciprocal scale
	localparam int MW = RS + 1 - FRAC_BITS;   // reciprocal / quotient width
	localparam int DW = FRAC_BITS + 4;        // divisor width
	localparam int PW = MW + DW;              // remainder width
	localparam int SIG_DIV  = SIG_RANGE << FRAC_BITS;
	localparam int TANH_DIV = TANH_LIMIT << FRAC_BITS;
	localparam longint SIG_BASE   = longint'(SIG_HALF) * SIG_DIV;
	localparam longint TANH_BASE  = longint'(TANH_HALF) * TANH_DIV;
	localparam longint SIG_RECIP  = (longint'(1) << RS) / SIG_DIV;
	localparam longint TANH_RECIP = (longint'(1) << RS) / TANH_DIV;
	localparam int MAX_IDX = 2 * ((SIG_HALF > TANH_HALF) ? SIG_HALF : TANH_HALF);

	logic signed [31:0]     half0;
	logic signed [31:0]     base0;
	logic signed [31:0]     n0;
	logic [NW-1:0]          n_s1;
	logic [NW-1:0]          n_s2;
	logic                   tanh_s1;
	logic                   tanh_s2;
	logic [MW-1:0]          recip1;
	logic [NW+MW-1:0]       pq_s2;
	logic [MW-1:0]          q0;
	logic [DW-1:0]          dsel2;
	logic [PW-1:0]          rem;
	logic [MW-1:0]          q1;

	// stage 0: scaled and offset dividend, negative means below the table
	always_comb begin
		half0 = use_tanh ? 32'(TANH_HALF) : 32'(SIG_HALF);
		base0 = use_tanh ? 32'(TANH_BASE) : 32'(SIG_BASE);
		n0 = 32'(x) * half0 + base0;
	end

	// stage 1: reciprocal multiply
	assign recip1 = tanh_s1 ? MW'(TANH_RECIP) : MW'(SIG_RECIP);

	// stage 2: estimate is exact or one low; fix with the remainder, clamp
	always_comb begin
		q0 = pq_s2[NW+MW-1:RS];
		dsel2 = tanh_s2 ? DW'(TANH_DIV) : DW'(SIG_DIV);
		rem = PW'(n_s2) - PW'(q0) * PW'(dsel2);
		q1 = q0 + MW'(rem >= PW'(dsel2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n0[31] ? '0 : n0[NW-1:0];
			tanh_s1 <= use_tanh;
			pq_s2 <= (NW+MW)'(n_s1) * (NW+MW)'(recip1);
			n_s2 <= n_s1;
			tanh_s2 <= tanh_s1;
			idx_s3 <= (32'(q1) > 32'(MAX_IDX)) ? IDX_W'(MAX_IDX) : q1[IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/afu_rom.sv
`default_nettype none

// Activation table with a registered read port
module afu_rom import afu_pkg::*; #(
	parameter int HALF      = 256,
	parameter int SPAN      = 8,
	parameter int FRAC_BITS = 12,
	parameter bit IS_TANH   = 1'b0,
	parameter int ADDR_W    = 10
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [ADDR_W-1:0] addr,
	output logic      [XW-1:0]     data_s4
);

	localparam int DEPTH = 2 * HALF + 1;
	localparam int RW = $clog2(DEPTH);

	logic [XW-1:0] rom [DEPTH];
	logic [RW-1:0] ra;

	// contents fixed at elaboration
	for (genvar g = 0; g < DEPTH; g++) begin : g_fill
		localparam logic [XW-1:0] V = rom_entry(IS_TANH, g, HALF, SPAN, FRAC_BITS);
		assign rom[g] = V;
	end

	// keep the address inside this table
	assign ra = (32'(addr) > DEPTH - 1) ? RW'(DEPTH - 1) : RW'(addr);

	always_ff @(posedge clk) begin
		if (en)
			data_s4 <= rom[ra];
	end

endmodule

`default_nettype wire

### hw/rtl/activation_function_unit.sv
// Channel   | Handshake                 | Word
// ----------+---------------------------+----------------------------------
// item      | item_valid / item_stall   | x_in (s16, Q4.12), last_in
// result    | result_valid / result_stall | y_out (s16, Q4.12), last_out
// cfg       | cfg_valid / cfg_ready     | cfg_data (activation mode, 3 b)
//
// One word per cycle in, one out, while result_stall does not hold a result.
// Between accept and result_valid lie the index path (offset multiply, reciprocal
// multiply, remainder correction), the registered table read and the output register.
// arst_n clears the valid bits and the mode (sigmoid); the tables are constant
// and need no clearing pass. cfg_ready is always high.
// result_stall on a held result freezes the whole pipeline and asserts item_stall
// in the same cycle.
`default_nettype none

`include "activation_function_unit_assert.svh"

module activation_function_unit import afu_pkg::*; #(
	parameter int SIG_HALF   = 256,
	parameter int SIG_RANGE  = 8,
	parameter int TANH_HALF  = 256,
	parameter int TANH_LIMIT = 4,
	parameter int FRAC_BITS  = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic signed [XW-1:0] x_in,
	input  wire logic                 last_in,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic signed [XW-1:0]      y_out,
	output logic                      last_out,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_data
);

	localparam int MAX_HALF = (SIG_HALF > TANH_HALF) ? SIG_HALF : TANH_HALF;
	localparam int JW = $clog2(2 * MAX_HALF + 1);
	localparam int FX_ONE_I = 1 << FRAC_BITS;
	localparam logic signed [XW-1:0] FX_ONE = XW'(FX_ONE_I);
	localparam int SIG_LIM  = SIG_RANGE << FRAC_BITS;
	localparam int TANH_LIM = TANH_LIMIT << FRAC_BITS;
	localparam logic signed [33:0] SAT_HI = 34'sd32767;
	localparam logic signed [33:0] SAT_LO = -34'sd32768;

	logic [2:0] mode_q;
	logic       en;
	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic       out_valid_q;

	// stage 0
	logic              use_tanh0;
	logic signed [31:0] xe0;
	logic signed [31:0] lim0;
	logic              hi0, lo0;
	logic signed [16:0] b0;

	// pipeline payload
	logic signed [XW-1:0] x_s1, x_s2, x_s3, x_s4;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic [2:0]           mode_s1, mode_s2, mode_s3, mode_s4;
	logic                 hi_s1, hi_s2, hi_s3, hi_s4;
	logic                 lo_s1, lo_s2, lo_s3, lo_s4;
	logic signed [32:0]   dprod_s1;
	logic signed [32:0]   sh1;
	logic signed [33:0]   dv1;
	logic signed [XW-1:0] der1;
	logic signed [XW-1:0] der_s2, der_s3, der_s4;
	logic [JW-1:0]        idx_s3;
	logic [XW-1:0]        sig_s4, tanh_s4;
	logic signed [XW-1:0] y_nxt;
	logic signed [XW-1:0] y_q;
	logic                 last_q;

	// pipeline moves unless a held result is stalled
	assign en = !(out_valid_q && result_stall);
	assign item_stall = !en;
	assign cfg_ready = 1'b1;
	assign result_valid = out_valid_q;
	assign y_out = y_q;
	assign last_out = last_q;

	// stage 0: range test, table select, derivative operand
	always_comb begin
		use_tanh0 = (mode_q == MODE_TANH);
		xe0 = 32'(x_in);
		lim0 = use_tanh0 ? 32'(TANH_LIM) : 32'(SIG_LIM);
		hi0 = xe0 > lim0;
		lo0 = xe0 < -lim0;
		b0 = (mode_q == MODE_SIG_DER) ? 17'(FX_ONE_I) - 17'(x_in) : 17'(x_in);
	end

	// stage 1: floor shift and saturate the derivative product
	always_comb begin
		sh1 = dprod_s1 >>> FRAC_BITS;
		dv1 = (mode_s1 == MODE_TANH_DER) ? 34'(FX_ONE_I) - 34'(sh1) : 34'(sh1);
		if (dv1 > SAT_HI)
			der1 = 16'sh7FFF;
		else if (dv1 < SAT_LO)
			der1 = 16'sh8000;
		else
			der1 = dv1[XW-1:0];
	end

	afu_index #(
		.SIG_HALF  (SIG_HALF),
		.SIG_RANGE (SIG_RANGE),
		.TANH_HALF (TANH_HALF),
		.TANH_LIMIT(TANH_LIMIT),
		.FRAC_BITS (FRAC_BITS),
		.IDX_W     (JW)
	) u_index (
		.clk     (clk),
		.en      (en),
		.use_tanh(use_tanh0),
		.x       (x_in),
		.idx_s3  (idx_s3)
	);

	afu_rom #(
		.HALF     (SIG_HALF),
		.SPAN     (SIG_RANGE),
		.FRAC_BITS(FRAC_BITS),
		.IS_TANH  (1'b0),
		.ADDR_W   (JW)
	) u_sig_rom (
		.clk    (clk),
		.en     (en),
		.addr   (idx_s3),
		.data_s4(sig_s4)
	);

	afu_rom #(
		.HALF     (TANH_HALF),
		.SPAN     (TANH_LIMIT),
		.FRAC_BITS(FRAC_BITS),
		.IS_TANH  (1'b1),
		.ADDR_W   (JW)
	) u_tanh_rom (
		.clk    (clk),
		.en     (en),
		.addr   (idx_s3),
		.data_s4(tanh_s4)
	);

	// stage 4: pick the result
	always_comb begin
		case (mode_s4)
			MODE_SIG: begin
				if (hi_s4)
					y_nxt = FX_ONE;
				else if (lo_s4)
					y_nxt = '0;
				else
					y_nxt = $signed(sig_s4);
			end
			MODE_SIG_DER, MODE_TANH_DER: y_nxt = der_s4;
			MODE_TANH: begin
				if (hi_s4)
					y_nxt = FX_ONE;
				else if (lo_s4)
					y_nxt = -FX_ONE;
				else
					y_nxt = $signed(tanh_s4);
			end
			MODE_IDENT: y_nxt = x_s4;
			MODE_ONE: y_nxt = FX_ONE;
			default: y_nxt = '0;
		endcase
	end

	// control: valid bits and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'(MODE_SIG);
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				mode_q <= cfg_data;
			if (en) begin
				valid_s1 <= item_valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
				out_valid_q <= valid_s4;
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_in;
			last_s1 <= last_in;
			mode_s1 <= mode_q;
			hi_s1 <= hi0;
			lo_s1 <= lo0;
			dprod_s1 <= 33'(x_in) * 33'(b0);

			x_s2 <= x_s1;
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
			hi_s2 <= hi_s1;
			lo_s2 <= lo_s1;
			der_s2 <= der1;

			x_s3 <= x_s2;
			last_s3 <= last_s2;
			mode_s3 <= mode_s2;
			hi_s3 <= hi_s2;
			lo_s3 <= lo_s2;
			der_s3 <= der_s2;

			x_s4 <= x_s3;
			last_s4 <= last_s3;
			mode_s4 <= mode_s3;
			hi_s4 <= hi_s3;
			lo_s4 <= lo_s3;
			der_s4 <= der_s3;

			y_q <= y_nxt;
			last_q <= last_s4;
		end
	end

	// checks
	`AFU_ASSERT_NEXT(a_hold_frozen, !en, $stable({valid_s1, valid_s2, valid_s3, valid_s4}), "pipeline moved during output stall")
	`AFU_ASSERT(a_sig_idx_range, (valid_s3 && mode_s3 == MODE_SIG && !hi_s3 && !lo_s3) |-> (32'(idx_s3) <= 2 * SIG_HALF), "sigmoid index outside table")
	`AFU_ASSERT(a_sig_nonneg, (valid_s4 && mode_s4 == MODE_SIG) |-> !y_nxt[XW-1], "negative sigmoid result")
	`AFU_ASSERT(a_tanh_der_max, (valid_s2 && mode_s2 == MODE_TANH_DER) |-> (der_s2 <= FX_ONE), "tanh derivative above one")

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import afu_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int FRAC        = 12;
	localparam longint FX_ONE  = longint'(1) <<< FRAC;
	localparam int SIG_N       = 256;
	localparam int SIG_SPAN    = 8;
	localparam int TANH_N      = 256;
	localparam int TANH_SPAN   = 4;
	localparam longint unsigned EXP_UNIT = 64'h0000_0001_0000_0000;
	localparam longint unsigned EXP_M1   = 64'd1580030169;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 60;

	// mode codes outside the defined set; the block must return zero for them
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic signed [XW-1:0] y;
		logic                 last;
	} act_word_t;

	typedef struct packed {
		logic [2:0]           mode;
		logic signed [XW-1:0] x;
		logic                 last;
		logic                 known;
		logic signed [XW-1:0] y;
	} dir_row_t;

	localparam int N_DIR = 24;
	// known = 1: expected y typed in; otherwise the predictor supplies it
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{MODE_SIG,      16'sd0,      1'b0, 1'b1, 16'sd2048},
		'{MODE_SIG,      16'sd32767,  1'b0, 1'b0, 16'sd0},
		'{MODE_SIG,      -16'sd32768, 1'b1, 1'b0, 16'sd0},
		'{MODE_SIG,      -16'sd1,     1'b0, 1'b0, 16'sd0},
		'{MODE_TANH,     16'sd0,      1'b0, 1'b1, 16'sd0},
		'{MODE_TANH,     16'sd16384,  1'b0, 1'b0, 16'sd0},
		'{MODE_TANH,     16'sd16385,  1'b0, 1'b1, 16'sd4096},
		'{MODE_TANH,     -16'sd16384, 1'b0, 1'b0, 16'sd0},
		'{MODE_TANH,     -16'sd16385, 1'b1, 1'b1, -16'sd4096},
		'{MODE_TANH,     16'sd32767,  1'b0, 1'b1, 16'sd4096},
		'{MODE_TANH,     -16'sd32768, 1'b0, 1'b1, -16'sd4096},
		'{MODE_SIG_DER,  16'sd2048,   1'b0, 1'b1, 16'sd1024},
		'{MODE_SIG_DER,  16'sd4096,   1'b0, 1'b1, 16'sd0},
		'{MODE_SIG_DER,  -16'sd1,     1'b0, 1'b1, -16'sd2},
		'{MODE_SIG_DER,  16'sd32767,  1'b1, 1'b1, -16'sd32768},
		'{MODE_SIG_DER,  -16'sd32768, 1'b0, 1'b1, -16'sd32768},
		'{MODE_TANH_DER, 16'sd0,      1'b0, 1'b1, 16'sd4096},
		'{MODE_TANH_DER, 16'sd4096,   1'b0, 1'b1, 16'sd0},
		'{MODE_TANH_DER, -16'sd32768, 1'b1, 1'b1, -16'sd32768},
		'{MODE_IDENT,    16'sd32767,  1'b0, 1'b1, 16'sd32767},
		'{MODE_IDENT,    -16'sd32768, 1'b1, 1'b1, -16'sd32768},
		'{MODE_ONE,      16'sd1234,   1'b0, 1'b1, 16'sd4096},
		'{MODE_SPARE_6,  16'sd100,    1'b1, 1'b1, 16'sd0},
		'{MODE_SPARE_7,  -16'sd5,     1'b0, 1'b1, 16'sd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic signed [XW-1:0] x_in;
	logic                 last_in;
	logic                 result_valid;
	logic                 result_stall;
	logic signed [XW-1:0] y_out;
	logic                 last_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           cfg_data;

	int        sig_tab [0:2*SIG_N];
	int        tanh_tab [0:2*TANH_N];
	logic [2:0] mode_now;
	act_word_t act_due [$];
	act_word_t act_head;
	int        mismatches;
	bit        idle_on;
	bit        hold_req;
	int        stall_left;
	bit        stall_pick;

	activation_function_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.x_in         (x_in),
		.last_in      (last_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.y_out        (y_out),
		.last_out     (last_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// e^-a, a and result in Q32: series on the fraction, e^-1 per integer step
	function automatic longint unsigned neg_exp(input longint unsigned a);
		longint unsigned whole;
		longint unsigned fr;
		longint unsigned term;
		longint unsigned v;
		longint acc;
		whole = a >> 32;
		fr = a & 64'h0000_0000_FFFF_FFFF;
		term = EXP_UNIT;
		acc = longint'(EXP_UNIT);
		for (int k = 1; k <= 20; k++) begin
			term = ((term * fr) >> 32) / 64'(k);
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = longint'(acc);
		for (longint unsigned k = 0; k < whole && v != 0; k++)
			v = (v * EXP_M1) >> 32;
		return v;
	endfunction

	// sigmoid and tanh tables, rounded half away from zero
	task automatic build_tables();
		longint d;
		longint unsigned ad;
		longint unsigned a;
		longint unsigned e;
		longint unsigned den;
		longint t;
		for (int j = 0; j <= 2 * SIG_N; j++) begin
			d = j - SIG_N;
			ad = (d < 0) ? -d : d;
			a = ad * SIG_SPAN * EXP_UNIT / SIG_N;
			e = neg_exp(a);
			den = EXP_UNIT + e;
			if (d >= 0)
				sig_tab[j] = int'(((EXP_UNIT << FRAC) + den / 2) / den);
			else
				sig_tab[j] = int'(((e << FRAC) + den / 2) / den);
		end
		for (int j = 0; j <= 2 * TANH_N; j++) begin
			d = j - TANH_N;
			ad = (d < 0) ? -d : d;
			a = ad * TANH_SPAN * EXP_UNIT / TANH_N;
			e = neg_exp(2 * a);
			den = EXP_UNIT + e;
			t = longint'((((EXP_UNIT - e) << FRAC) + den / 2) / den);
			tanh_tab[j] = int'((d < 0) ? -t : t);
		end
	endtask

	function automatic longint sat_word(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// floor(x*n/(span<<FRAC)) + n, clamped to the table
	function automatic int tab_index(input longint xv, input int n, input int span);
		longint num;
		longint den;
		longint q;
		num = xv * n;
		den = longint'(span) <<< FRAC;
		q = num / den;
		if (num % den != 0 && num < 0)
			q = q - 1;
		q = q + n;
		if (q < 0)
			q = 0;
		if (q > 2 * n)
			q = 2 * n;
		return int'(q);
	endfunction

	function automatic logic signed [XW-1:0] activate(input logic [2:0] mode,
			input logic signed [XW-1:0] x);
		longint xv;
		longint lim;
		longint r;
		xv = x;
		r = 0;
		case (mode)
		MODE_SIG: begin
			lim = longint'(SIG_SPAN) <<< FRAC;
			if (xv > lim)
				r = FX_ONE;
			else if (xv < -lim)
				r = 0;
			else
				r = sig_tab[tab_index(xv, SIG_N, SIG_SPAN)];
		end
		MODE_SIG_DER: r = sat_word((xv * (FX_ONE - xv)) >>> FRAC);
		MODE_TANH: begin
			lim = longint'(TANH_SPAN) <<< FRAC;
			if (xv > lim)
				r = FX_ONE;
			else if (xv < -lim)
				r = -FX_ONE;
			else
				r = tanh_tab[tab_index(xv, TANH_N, TANH_SPAN)];
		end
		MODE_TANH_DER: r = sat_word(FX_ONE - ((xv * xv) >>> FRAC));
		MODE_IDENT: r = xv;
		MODE_ONE: r = FX_ONE;
		default: r = 0;
		endcase
		return XW'(r);
	endfunction

	// mostly in or near the table ranges, some full-scale noise
	function automatic logic signed [XW-1:0] rand_x();
		int r;
		int b;
		r = $urandom_range(0, 99);
		if (r < 35)
			return XW'($urandom);
		if (r < 65)
			return XW'(int'($urandom_range(0, 33024)) - 16512);
		if (r < 78) begin
			b = 16384 + int'($urandom_range(0, 4)) - 2;
			return XW'($urandom_range(0, 1) ? b : -b);
		end
		if (r < 84)
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return XW'(int'($urandom_range(0, 16384)) - 8192);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// offer one word, called at a falling edge; returns at a falling edge
	task automatic offer(input logic signed [XW-1:0] x, input logic last,
			input bit known, input logic signed [XW-1:0] known_y);
		int gap;
		act_word_t w;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		x_in <= x;
		last_in <= last;
		do
			@(posedge clk);
		while (item_stall);
		w.y = known ? known_y : activate(mode_now, x);
		w.last = last;
		act_due.push_back(w);
		@(negedge clk);
	endtask

	// stop sending and wait for every expected word
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (act_due.size() != 0);
	endtask

	task automatic set_mode(input logic [2:0] m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		mode_now = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver back-pressure: random runs, plus a long hold on request
	initial begin
		result_stall = 1'b0;
		stall_left = 0;
		stall_pick = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				stall_left = 0;
				result_stall <= 1'b0;
			end else if (!idle_on) begin
				result_stall <= 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_pick = ($urandom_range(0, 99) < 35);
					stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(8, 25);
				end
				result_stall <= stall_pick;
				stall_left--;
			end
		end
	end

	// compare each delivered word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (act_due.size() == 0) begin
				$display("%0t: unexpected word y_out=%0d last_out=%0b", $time,
					$signed(y_out), last_out);
				mismatches++;
			end else begin
				act_head = act_due.pop_front();
				if (y_out !== act_head.y || last_out !== act_head.last) begin
					$display("%0t: mismatch: expected y=%0d last=%0b, got y=%0d last=%0b",
						$time, $signed(act_head.y), act_head.last, $signed(y_out),
						last_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		afu_mode_t phase_order [6];
		logic [2:0] m;
		phase_order = '{MODE_SIG, MODE_TANH, MODE_SIG_DER, MODE_TANH_DER,
			MODE_IDENT, MODE_ONE};
		arst_n = 1'b0;
		item_valid = 1'b0;
		x_in = '0;
		last_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = MODE_SIG;
		mode_now = MODE_SIG;
		mismatches = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		build_tables();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words; the first rows run in the mode left by reset
		for (int i = 0; i < N_DIR; i++) begin
			if (DIR_ROWS[i].mode != mode_now)
				set_mode(DIR_ROWS[i].mode);
			offer(DIR_ROWS[i].x, DIR_ROWS[i].last, DIR_ROWS[i].known, DIR_ROWS[i].y);
		end

		// random phases, each with its own mode
		for (int p = 0; p < PHASES; p++) begin
			m = (p < 6) ? phase_order[p] : 3'($urandom_range(0, 5));
			set_mode(m);
			idle_on = (p % 4 != 3);
			// long receiver hold while the sender keeps pushing
			if (p == 2 || p == 9)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (p == 7 && i == PHASE_WORDS / 2)
					drain();
				offer(rand_x(), ($urandom_range(0, 7) == 0), 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && act_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### activation_function_unit.f
+incdir+hw/rtl
hw/rtl/afu_pkg.sv
hw/rtl/afu_index.sv
hw/rtl/afu_rom.sv
hw/rtl/activation_function_unit.sv
dv/testbench.sv
